// ----- hdl/ray_cone_intersect_macros.svh -----
// Assertion macros shared by the ray/cone intersection RTL.
`ifndef RAY_CONE_INTERSECT_MACROS_SVH
`define RAY_CONE_INTERSECT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while rst_n is low.
`define RCI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_cone_intersect: assertion failed");

// Next-cycle implication, sampled on clk, muted while rst_n is low.
`define RCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_cone_intersect: assertion failed");

`endif

// ----- hdl/rci_pkg.sv -----
// Shared constants and types for the ray/cone intersection pipeline.
package rci_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TENTH         = ((1 << FRACTION_BITS) + 5) / 10;

    localparam int COORD_W = 32;
    localparam int REG_W   = 31;

    // wide multiplier: MUL_ND x MUL_ND digits of MUL_DIG bits
    localparam int MUL_DIG = 32;
    localparam int MUL_ND  = 4;
    localparam int MUL_W   = MUL_DIG * MUL_ND;
    localparam int MUL_LAT = 4;

    // square root of the discriminant
    localparam int ROOT_W = 128;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // numerator and quotient of the root division
    localparam int NUM_W = MUL_W + 2;
    localparam int QUO_W = 31;
    localparam int DIV_W = 160;

    typedef enum logic [0:0] {
        CFG_RADIUS = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// ----- hdl/ray_cone_intersect.sv -----
// Top level: pipelined ray versus finite y-axis cone intersection.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  ray in    | start, busy          | origin_x/y/z, direction_x/y/z, current_best
//  result    | done (strobe)        | hit, new_best
//  config    | cfg_we               | cfg_index, cfg_data
//
// One ray is taken every cycle; results appear on done in the order the rays were
// taken. The pipeline depth is set by the 128-stage discriminant square root,
// the 31-stage restoring divider and two 4-stage wide multiplier levels.
// rst_n clears the valid chain, the result strobe and the cone registers
// (radius and height back to 1.0); datapath registers are not reset.
// The receiver cannot stall, so the pipeline never holds: busy stays low.
`include "ray_cone_intersect_macros.svh"

module ray_cone_intersect import rci_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [REG_W-1:0]          cfg_data,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] direction_x,
    input  logic signed [COORD_W-1:0] direction_y,
    input  logic signed [COORD_W-1:0] direction_z,
    input  logic signed [COORD_W-1:0] current_best,
    output logic                      done,
    output logic                      hit,
    output logic signed [COORD_W-1:0] new_best
);

    // registers from ray transfer to result strobe
    localparam int LAT = 3 + MUL_LAT + 2 + MUL_LAT + 1 + ROOT_W + 2 + QUO_W + 2;
    localparam int PW  = 2 * MUL_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] best;
    } ray_t;

    // coefficient signs and magnitudes riding along the second multiplier level
    typedef struct packed {
        logic signed [MUL_W-1:0] b;
        logic [MUL_W-1:0]        m;
        logic                    a_neg;
        logic                    a_zero;
        logic                    ac_neg;
    } coef_side_t;

    // what the root and the division need besides the discriminant
    typedef struct packed {
        logic signed [MUL_W-1:0] b;
        logic [MUL_W-1:0]        m;
        logic                    a_neg;
        logic                    ok;
    } sq_side_t;

    logic                 accept;
    logic [REG_W-1:0]     radius_reg;
    logic [REG_W-1:0]     height_reg;

    // valid chain and the ray fields needed at the end
    logic                 vld_reg   [LAT-1];
    ray_t                 ray_dly_reg[LAT-1];
    logic                 done_reg;
    logic                 hit_reg;
    logic signed [COORD_W-1:0] new_best_reg;

    // input capture
    logic signed [COORD_W-1:0] ox_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic signed [COORD_W:0]   hm_reg;
    logic signed [COORD_W:0]   hm_next;

    // first-level products
    logic [2*REG_W-1:0]        h2_reg, r2_reg;
    logic signed [63:0]        dxx_reg, dzz_reg, oxdx_reg, ozdz_reg, oxx_reg, ozz_reg, dyy_reg;
    logic signed [64:0]        dyhm_reg;
    logic signed [65:0]        hmm_reg;

    // sums and magnitudes
    logic [64:0]               sb_sum, dyhm_abs;
    logic [63:0]               sa_reg, sb_mag_reg, sc_reg, dyy_mag_reg, dyhm_mag_reg, hmm_mag_reg;
    logic                      sb_neg_reg, dyhm_neg_reg;
    logic [2*REG_W-1:0]        h2s_reg, r2s_reg;
    logic                      sb_neg_dly_reg  [MUL_LAT];
    logic                      dyhm_neg_dly_reg[MUL_LAT];

    logic [PW-1:0]             p_a1, p_a2, p_b1, p_b2, p_c1, p_c2, p_bb, p_ac;

    // A, B, C
    logic signed [MUL_W-1:0]   a_reg, b_reg, c_reg;
    logic [MUL_W-1:0]          pb1_s, pb2_s;
    logic [MUL_W-1:0]          a_mag_reg, b_mag_reg, c_mag_reg;
    coef_side_t                coef_reg;
    coef_side_t                coef_dly_reg[MUL_LAT];

    // discriminant
    logic [RAD_W-1:0]          d_next;
    logic [RAD_W-1:0]          d_reg;
    sq_side_t                  d_side_reg;

    // square root stages
    logic [REM_W-1:0]          sq_rem_reg [ROOT_W];
    logic [ROOT_W-1:0]         sq_root_reg[ROOT_W];
    logic [RAD_W-1:0]          sq_rad_reg [ROOT_W];
    sq_side_t                  sq_side_reg[ROOT_W];

    // numerator and range check
    logic signed [NUM_W-1:0]   bx, sx, n_next;
    logic signed [NUM_W-1:0]   n_reg;
    logic [MUL_W-1:0]          n_m_reg;
    logic                      n_ok_reg;
    logic [DIV_W-1:0]          num_w, lim_w;
    logic [DIV_W-1:0]          dv0_rem_reg;
    logic [MUL_W-1:0]          dv0_m_reg;
    logic                      dv0_ok_reg;

    // division stages
    logic [DIV_W-1:0]          dv_rem_reg[QUO_W];
    logic [QUO_W-1:0]          dv_q_reg  [QUO_W];
    logic [MUL_W-1:0]          dv_m_reg  [QUO_W];
    logic                      dv_ok_reg [QUO_W];

    // hit height and final decision
    logic signed [63:0]        qdy_reg;
    logic [QUO_W-1:0]          qy_reg;
    logic                      qy_ok_reg;
    logic signed [63:0]        y_val;
    logic [63:0]               y_lim;
    logic signed [COORD_W-1:0] q_s;
    logic                      hit_next;
    ray_t                      ray_out;

    // ------------------------------------------------------------------
    // handshake and configuration
    // ------------------------------------------------------------------
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= REG_W'(1) << FRACTION_BITS;
            height_reg <= REG_W'(1) << FRACTION_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    radius_reg <= radius_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // valid chain: advance one slot a cycle, never hold
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT - 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < LAT - 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // origin y, direction y and best distance also ride along to the tail, where they are used
    always_ff @(posedge clk)
    begin
        ray_dly_reg[0].oy   <= origin_y;
        ray_dly_reg[0].dy   <= direction_y;
        ray_dly_reg[0].best <= current_best;
        for (int k = 1; k < LAT - 1; k++)
        begin
            ray_dly_reg[k] <= ray_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage: capture the ray, form H - oy
    // ------------------------------------------------------------------
    assign hm_next = $signed({2'b00, height_reg}) - {origin_y[COORD_W-1], origin_y};

    always_ff @(posedge clk)
    begin
        ox_reg <= origin_x;
        oz_reg <= origin_z;
        dx_reg <= direction_x;
        dy_reg <= direction_y;
        dz_reg <= direction_z;
        hm_reg <= hm_next;
    end

    // ------------------------------------------------------------------
    // stage: narrow products (about 32 x 32 each)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        h2_reg   <= height_reg * height_reg;
        r2_reg   <= radius_reg * radius_reg;
        dxx_reg  <= dx_reg * dx_reg;
        dzz_reg  <= dz_reg * dz_reg;
        oxdx_reg <= ox_reg * dx_reg;
        ozdz_reg <= oz_reg * dz_reg;
        oxx_reg  <= ox_reg * ox_reg;
        ozz_reg  <= oz_reg * oz_reg;
        dyy_reg  <= dy_reg * dy_reg;
        dyhm_reg <= dy_reg * hm_reg;
        hmm_reg  <= hm_reg * hm_reg;
    end

    // ------------------------------------------------------------------
    // stage: pair sums, split into sign and magnitude for the multipliers
    // ------------------------------------------------------------------
    assign sb_sum   = {oxdx_reg[63], oxdx_reg} + {ozdz_reg[63], ozdz_reg};
    assign dyhm_abs = dyhm_reg[64] ? 65'(-dyhm_reg) : 65'(dyhm_reg);

    always_ff @(posedge clk)
    begin
        sa_reg       <= $unsigned(dxx_reg) + $unsigned(dzz_reg);
        sc_reg       <= $unsigned(oxx_reg) + $unsigned(ozz_reg);
        sb_neg_reg   <= sb_sum[64];
        sb_mag_reg   <= sb_sum[64] ? 64'(-sb_sum) : sb_sum[63:0];
        dyy_mag_reg  <= $unsigned(dyy_reg);
        dyhm_neg_reg <= dyhm_reg[64];
        dyhm_mag_reg <= dyhm_abs[63:0];
        hmm_mag_reg  <= hmm_reg[63:0];
        h2s_reg      <= h2_reg;
        r2s_reg      <= r2_reg;
    end

    // ------------------------------------------------------------------
    // first wide level: H^2 and R^2 against the sums
    // ------------------------------------------------------------------
    rci_mul u_mul_a1 (.clk(clk), .a(MUL_W'(h2s_reg)), .b(MUL_W'(sa_reg)),       .p(p_a1));
    rci_mul u_mul_a2 (.clk(clk), .a(MUL_W'(r2s_reg)), .b(MUL_W'(dyy_mag_reg)),  .p(p_a2));
    rci_mul u_mul_b1 (.clk(clk), .a(MUL_W'(h2s_reg)), .b(MUL_W'(sb_mag_reg)),   .p(p_b1));
    rci_mul u_mul_b2 (.clk(clk), .a(MUL_W'(r2s_reg)), .b(MUL_W'(dyhm_mag_reg)), .p(p_b2));
    rci_mul u_mul_c1 (.clk(clk), .a(MUL_W'(h2s_reg)), .b(MUL_W'(sc_reg)),       .p(p_c1));
    rci_mul u_mul_c2 (.clk(clk), .a(MUL_W'(r2s_reg)), .b(MUL_W'(hmm_mag_reg)),  .p(p_c2));

    // hold the signs of B's two terms alongside the multipliers
    always_ff @(posedge clk)
    begin
        sb_neg_dly_reg[0]   <= sb_neg_reg;
        dyhm_neg_dly_reg[0] <= dyhm_neg_reg;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            sb_neg_dly_reg[k]   <= sb_neg_dly_reg[k-1];
            dyhm_neg_dly_reg[k] <= dyhm_neg_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage: A, B (half linear term) and C; every term stays below 2^126
    // ------------------------------------------------------------------
    assign pb1_s = sb_neg_dly_reg[MUL_LAT-1]   ? -p_b1[MUL_W-1:0] : p_b1[MUL_W-1:0];
    assign pb2_s = dyhm_neg_dly_reg[MUL_LAT-1] ? -p_b2[MUL_W-1:0] : p_b2[MUL_W-1:0];

    always_ff @(posedge clk)
    begin
        a_reg <= p_a1[MUL_W-1:0] - p_a2[MUL_W-1:0];
        b_reg <= pb1_s + pb2_s;
        c_reg <= p_c1[MUL_W-1:0] - p_c2[MUL_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage: magnitudes for B^2 and A*C
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        a_mag_reg       <= a_reg[MUL_W-1] ? -a_reg : a_reg;
        b_mag_reg       <= b_reg[MUL_W-1] ? -b_reg : b_reg;
        c_mag_reg       <= c_reg[MUL_W-1] ? -c_reg : c_reg;
        coef_reg.b      <= b_reg;
        coef_reg.m      <= a_reg[MUL_W-1] ? -a_reg : a_reg;
        coef_reg.a_neg  <= a_reg[MUL_W-1];
        coef_reg.a_zero <= (a_reg == '0);
        coef_reg.ac_neg <= a_reg[MUL_W-1] ^ c_reg[MUL_W-1];
    end

    rci_mul u_mul_bb (.clk(clk), .a(b_mag_reg), .b(b_mag_reg), .p(p_bb));
    rci_mul u_mul_ac (.clk(clk), .a(a_mag_reg), .b(c_mag_reg), .p(p_ac));

    always_ff @(posedge clk)
    begin
        coef_dly_reg[0] <= coef_reg;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            coef_dly_reg[k] <= coef_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage: D = B^2 - A*C; a near root exists only for A != 0 and D > 0
    // ------------------------------------------------------------------
    assign d_next = coef_dly_reg[MUL_LAT-1].ac_neg ? (p_bb + p_ac) : (p_bb - p_ac);

    always_ff @(posedge clk)
    begin
        d_reg            <= d_next;
        d_side_reg.b     <= coef_dly_reg[MUL_LAT-1].b;
        d_side_reg.m     <= coef_dly_reg[MUL_LAT-1].m;
        d_side_reg.a_neg <= coef_dly_reg[MUL_LAT-1].a_neg;
        d_side_reg.ok    <= !coef_dly_reg[MUL_LAT-1].a_zero && !d_next[RAD_W-1]
                            && (d_next != '0);
    end

    // ------------------------------------------------------------------
    // floor square root of D: one result bit per stage, two radicand bits in
    // ------------------------------------------------------------------
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        sq_side_t          side_in;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = d_reg;
            assign side_in = d_side_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            sq_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            sq_root_reg[k] <= {root_in[ROOT_W-2:0], ge};
            sq_rad_reg[k]  <= rad_in << 2;
            sq_side_reg[k] <= side_in;
        end
    end

    // ------------------------------------------------------------------
    // stage: numerator of the near root, N = -sgn(A) B - sqrt(D)
    // ------------------------------------------------------------------
    assign bx     = {{2{sq_side_reg[ROOT_W-1].b[MUL_W-1]}}, sq_side_reg[ROOT_W-1].b};
    assign sx     = {2'b00, sq_root_reg[ROOT_W-1]};
    assign n_next = sq_side_reg[ROOT_W-1].a_neg ? (bx - sx) : (-bx - sx);

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        n_m_reg  <= sq_side_reg[ROOT_W-1].m;
        n_ok_reg <= sq_side_reg[ROOT_W-1].ok;
    end

    // ------------------------------------------------------------------
    // stage: drop nonpositive roots and roots of 2^31 raw units or more
    // ------------------------------------------------------------------
    assign num_w = DIV_W'(n_reg[NUM_W-2:0]) << FRACTION_BITS;
    assign lim_w = DIV_W'(n_m_reg) << QUO_W;

    always_ff @(posedge clk)
    begin
        dv0_rem_reg <= num_w;
        dv0_m_reg   <= n_m_reg;
        dv0_ok_reg  <= n_ok_reg && !n_reg[NUM_W-1] && (n_reg != '0) && (num_w < lim_w);
    end

    // ------------------------------------------------------------------
    // restoring division (N << F) / |A|, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [DIV_W-1:0] rem_in;
        logic [QUO_W-1:0] q_in;
        logic [MUL_W-1:0] m_in;
        logic             ok_in;
        logic [DIV_W-1:0] dsub;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rem_in = dv0_rem_reg;
            assign q_in   = '0;
            assign m_in   = dv0_m_reg;
            assign ok_in  = dv0_ok_reg;
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign m_in   = dv_m_reg[j-1];
            assign ok_in  = dv_ok_reg[j-1];
        end

        assign dsub = DIV_W'(m_in) << (QUO_W - 1 - j);
        assign ge   = (rem_in >= dsub);

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j] <= ge ? (rem_in - dsub) : rem_in;
            dv_q_reg[j]   <= {q_in[QUO_W-2:0], ge};
            dv_m_reg[j]   <= m_in;
            dv_ok_reg[j]  <= ok_in;
        end
    end

    // ------------------------------------------------------------------
    // stage: t * dy for the hit height
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        qdy_reg   <= $signed({1'b0, dv_q_reg[QUO_W-1]}) * ray_dly_reg[LAT-3].dy;
        qy_reg    <= dv_q_reg[QUO_W-1];
        qy_ok_reg <= dv_ok_reg[QUO_W-1];
    end

    // ------------------------------------------------------------------
    // stage: height window, tenth floor, nearer than best; drive the result
    // ------------------------------------------------------------------
    assign ray_out  = ray_dly_reg[LAT-2];
    assign q_s      = $signed({1'b0, qy_reg});
    assign y_val    = ($signed(64'(ray_out.oy)) <<< FRACTION_BITS) + qdy_reg;
    assign y_lim    = {33'b0, height_reg} << FRACTION_BITS;
    assign hit_next = qy_ok_reg && (q_s > TENTH) && !y_val[63]
                      && ($unsigned(y_val) <= y_lim) && (q_s < ray_out.best);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[LAT-2];
            hit_reg  <= vld_reg[LAT-2] && hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_best_reg <= hit_next ? q_s : ray_out.best;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign new_best = new_best_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RCI_ASSERT_IMPL(a_fixed_latency, done, $past(start && !busy, LAT))
    `RCI_ASSERT_IMPL(a_hit_with_strobe, hit, done)
    `RCI_ASSERT_IMPL(a_hit_is_nearer, hit, new_best < $past(current_best, LAT))
    `RCI_ASSERT_IMPL(a_miss_keeps_best, done && !hit, new_best == $past(current_best, LAT))
    `RCI_ASSERT_NEXT(a_no_stray_strobe, !vld_reg[LAT-2], !done)

endmodule

// ----- hdl/rci_mul.sv -----
// Pipelined unsigned wide multiplier built from digit partial products.
module rci_mul import rci_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   p
);

    localparam int ROW_W = MUL_W + MUL_DIG;
    localparam int PW    = 2 * MUL_W;
    localparam int NPAIR = MUL_ND / 2;

    logic [2*MUL_DIG-1:0] pp_reg   [MUL_ND][MUL_ND];
    logic [ROW_W-1:0]     row_reg  [MUL_ND];
    logic [ROW_W-1:0]     row_next [MUL_ND];
    logic [PW-1:0]        pair_reg [NPAIR];
    logic [PW-1:0]        pair_next[NPAIR];
    logic [PW-1:0]        p_reg;
    logic [PW-1:0]        p_next;

    // digit products, one register level
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MUL_ND; i++)
        begin
            for (int j = 0; j < MUL_ND; j++)
            begin
                pp_reg[i][j] <= a[i*MUL_DIG +: MUL_DIG] * b[j*MUL_DIG +: MUL_DIG];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MUL_ND; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < MUL_ND; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (MUL_DIG * j));
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NPAIR; k++)
        begin
            pair_next[k] = PW'(row_reg[2*k]) + (PW'(row_reg[2*k+1]) << MUL_DIG);
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int k = 0; k < NPAIR; k++)
        begin
            p_next = p_next + (pair_reg[k] << (2 * MUL_DIG * k));
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        pair_reg <= pair_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule
